// ----- rtl/adrp_pkg.sv -----
package adrp_pkg;

   // input item: one PDU byte with the whole PDU length
   typedef struct packed {
      logic [7:0] pdu_byte;
      logic [7:0] pdu_length;
   } adrp_req_type;

   // result item
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] first_handle;
      logic [15:0] group_end_handle;
      logic [63:0] uuid_upper;
      logic [63:0] uuid_lower;
      logic [2:0]  parse_status;
      logic        final_handle_valid;
      logic [15:0] final_handle;
      logic        run_last;
   } adrp_rsp_type;

   // up to two results from one byte: an entry record, then the summary
   typedef struct packed {
      logic         rec_valid;
      adrp_rsp_type rec;
      logic         sum_valid;
      adrp_rsp_type sum;
   } adrp_pair_type;

   typedef enum logic [1:0] {
      KIND_GROUP   = 2'd0,
      KIND_INFO    = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BAD_OPCODE   = 3'd1,
      ST_EMPTY_BODY   = 3'd2,
      ST_BAD_LENGTH   = 3'd3,
      ST_NOT_MULTIPLE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      RESP_NONE  = 2'd0,
      RESP_GROUP = 2'd1,
      RESP_INFO  = 2'd2
   } resp_kind_type;

   localparam logic [7:0]  OP_GROUP_RESP   = 8'h11;
   localparam logic [7:0]  OP_INFO_RESP    = 8'h05;
   localparam logic [7:0]  FMT_SHORT       = 8'h01;
   localparam logic [7:0]  GROUP_SHORT_LEN = 8'd6;
   localparam logic [7:0]  GROUP_LONG_LEN  = 8'd20;
   localparam logic [4:0]  INFO_SHORT_LEN  = 5'd4;
   localparam logic [4:0]  INFO_LONG_LEN   = 5'd18;
   localparam logic [4:0]  GROUP_HBYTES    = 5'd4;
   localparam logic [4:0]  INFO_HBYTES     = 5'd2;
   localparam logic [4:0]  SHORT_UUID_LEN  = 5'd2;
   localparam logic [31:0] BASE_UPPER_LOW  = 32'h0000_1000;
   localparam logic [63:0] BASE_LOWER      = 64'h8000_0080_5F9B_34FB;

   // reciprocals for dividing an 8-bit body length by the entry size
   localparam logic [15:0] RECIP_6  = 16'd171;  // >> 10
   localparam logic [15:0] RECIP_18 = 16'd57;   // >> 10
   localparam logic [15:0] RECIP_20 = 16'd205;  // >> 12

   localparam int ENT_W      = 6;
   localparam int FIFO_DEPTH = 4;

endpackage

// ----- rtl/adrp_parser.sv -----
module adrp_parser #(
   parameter int MAX_PDU_BYTES = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  adrp_pkg::adrp_req_type item,
   output adrp_pkg::adrp_pair_type results
);

   localparam int LW = $clog2(MAX_PDU_BYTES + 256);
   localparam int PW = $clog2(MAX_PDU_BYTES);
   localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PDU_BYTES);

   logic [PW-1:0]             pos_ff, pos_in;
   adrp_pkg::resp_kind_type   resp_kind_ff, resp_kind_in;
   logic [4:0]                entry_len_ff, entry_len_in;
   logic [4:0]                idx_ff, idx_in;
   logic [adrp_pkg::ENT_W-1:0] remain_ff, remain_in;
   logic [31:0]               handle_ff, handle_in;
   logic [63:0]               uuid_hi_ff, uuid_hi_in;
   logic [63:0]               uuid_lo_ff, uuid_lo_in;
   logic [15:0]               prev_handle_ff, prev_handle_in;
   adrp_pkg::status_type      err_ff, err_in;
   logic                      seen_ff, seen_in;

   logic [LW-1:0] raw_len;
   logic [LW-1:0] len;
   logic          last;
   logic [7:0]    b;
   logic [7:0]    body;
   logic [15:0]   prod6, prod18, prod20;
   logic [5:0]    q6, q18, q20, q4;
   logic [4:0]    hbytes;
   logic [4:0]    ubyte;
   logic          short_uuid;

   assign b       = item.pdu_byte;
   assign raw_len = LW'(item.pdu_length);
   assign len     = (raw_len == '0) ? LW'(1) : ((raw_len > MAX_LEN) ? MAX_LEN : raw_len);
   assign last    = (LW'(pos_ff) + LW'(1)) >= len;
   // len never exceeds 255 here
   assign body    = (len >= LW'(2)) ? 8'(len - LW'(2)) : 8'd0;

   assign prod6  = 16'(body) * adrp_pkg::RECIP_6;
   assign prod18 = 16'(body) * adrp_pkg::RECIP_18;
   assign prod20 = 16'(body) * adrp_pkg::RECIP_20;
   assign q6     = prod6[15:10];
   assign q18    = prod18[15:10];
   assign q20    = 6'(prod20[15:12]);
   assign q4     = body[7:2];

   assign hbytes     = (resp_kind_ff == adrp_pkg::RESP_GROUP) ?
                       adrp_pkg::GROUP_HBYTES : adrp_pkg::INFO_HBYTES;
   assign ubyte      = idx_ff - hbytes;
   assign short_uuid = (entry_len_ff - hbytes) == adrp_pkg::SHORT_UUID_LEN;

   always_comb begin
      pos_in         = pos_ff;
      resp_kind_in   = resp_kind_ff;
      entry_len_in   = entry_len_ff;
      idx_in         = idx_ff;
      remain_in      = remain_ff;
      handle_in      = handle_ff;
      uuid_hi_in     = uuid_hi_ff;
      uuid_lo_in     = uuid_lo_ff;
      prev_handle_in = prev_handle_ff;
      err_in         = err_ff;
      seen_in        = seen_ff;
      results        = '0;

      if (pos_ff == '0) begin
         // opcode byte starts a new PDU
         entry_len_in   = '0;
         idx_in         = '0;
         remain_in      = '0;
         prev_handle_in = '0;
         seen_in        = 1'b0;
         err_in         = adrp_pkg::ST_OK;
         case (b)
            adrp_pkg::OP_GROUP_RESP: resp_kind_in = adrp_pkg::RESP_GROUP;
            adrp_pkg::OP_INFO_RESP:  resp_kind_in = adrp_pkg::RESP_INFO;
            default: begin
               resp_kind_in = adrp_pkg::RESP_NONE;
               err_in       = adrp_pkg::ST_BAD_OPCODE;
            end
         endcase
         if (last && err_in == adrp_pkg::ST_OK) begin
            err_in = adrp_pkg::ST_EMPTY_BODY;
         end
      end else if (err_ff == adrp_pkg::ST_OK) begin
         if (pos_ff == PW'(1)) begin
            if (resp_kind_ff == adrp_pkg::RESP_GROUP) begin
               if (b == adrp_pkg::GROUP_SHORT_LEN) begin
                  if (body != 8'({2'b00, q6} * 8'd6)) begin
                     err_in = adrp_pkg::ST_NOT_MULTIPLE;
                  end else begin
                     entry_len_in = b[4:0];
                     remain_in    = q6;
                  end
               end else if (b == adrp_pkg::GROUP_LONG_LEN) begin
                  if (body != 8'({2'b00, q20} * 8'd20)) begin
                     err_in = adrp_pkg::ST_NOT_MULTIPLE;
                  end else begin
                     entry_len_in = b[4:0];
                     remain_in    = q20;
                  end
               end else begin
                  err_in = adrp_pkg::ST_BAD_LENGTH;
               end
            end else if (b == adrp_pkg::FMT_SHORT) begin
               entry_len_in = adrp_pkg::INFO_SHORT_LEN;
               remain_in    = q4;
            end else begin
               entry_len_in = adrp_pkg::INFO_LONG_LEN;
               remain_in    = q18;
            end
         end else if (remain_ff != '0) begin
            // handles come first, then the UUID least significant byte first
            for (int i = 0; i < 4; i++) begin
               if (idx_ff < hbytes && idx_ff[1:0] == 2'(i)) begin
                  handle_in[8*i +: 8] = b;
               end
            end
            for (int i = 0; i < 8; i++) begin
               if (idx_ff >= hbytes && ubyte[2:0] == 3'(i)) begin
                  if (ubyte[4:3] == 2'd0) begin
                     uuid_lo_in[8*i +: 8] = b;
                  end else if (ubyte[4:3] == 2'd1) begin
                     uuid_hi_in[8*i +: 8] = b;
                  end
               end
            end
            if ((idx_ff + 5'd1) >= entry_len_ff) begin
               results.rec_valid = fire;
               results.rec.first_handle = handle_in[15:0];
               if (short_uuid) begin
                  results.rec.uuid_upper = {16'h0000, uuid_lo_in[15:0],
                                            adrp_pkg::BASE_UPPER_LOW};
                  results.rec.uuid_lower = adrp_pkg::BASE_LOWER;
               end else begin
                  results.rec.uuid_upper = uuid_hi_in;
                  results.rec.uuid_lower = uuid_lo_in;
               end
               if (resp_kind_ff == adrp_pkg::RESP_GROUP) begin
                  results.rec.kind             = adrp_pkg::KIND_GROUP;
                  results.rec.group_end_handle = handle_in[31:16];
                  prev_handle_in               = handle_in[31:16];
               end else begin
                  results.rec.kind = adrp_pkg::KIND_INFO;
                  prev_handle_in   = handle_in[15:0];
               end
               results.rec.run_last = !last;
               seen_in   = 1'b1;
               remain_in = remain_ff - 1'b1;
               idx_in    = '0;
            end else begin
               idx_in = idx_ff + 5'd1;
            end
         end
      end

      if (last) begin
         results.sum_valid         = fire;
         results.sum.kind          = adrp_pkg::KIND_SUMMARY;
         results.sum.parse_status  = err_in;
         results.sum.run_last      = 1'b1;
         if (err_in == adrp_pkg::ST_OK &&
             (resp_kind_in == adrp_pkg::RESP_INFO || seen_in)) begin
            results.sum.final_handle_valid = 1'b1;
            results.sum.final_handle       = prev_handle_in;
         end
         pos_in = '0;
      end else begin
         pos_in = PW'(pos_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         resp_kind_ff   <= adrp_pkg::RESP_NONE;
         entry_len_ff   <= '0;
         idx_ff         <= '0;
         remain_ff      <= '0;
         prev_handle_ff <= '0;
         err_ff         <= adrp_pkg::ST_OK;
         seen_ff        <= 1'b0;
      end else if (fire) begin
         pos_ff         <= pos_in;
         resp_kind_ff   <= resp_kind_in;
         entry_len_ff   <= entry_len_in;
         idx_ff         <= idx_in;
         remain_ff      <= remain_in;
         prev_handle_ff <= prev_handle_in;
         err_ff         <= err_in;
         seen_ff        <= seen_in;
      end
   end

   // entry accumulators: every byte read at entry end is written within the entry
   always_ff @(posedge clock) begin
      if (fire) begin
         handle_ff  <= handle_in;
         uuid_hi_ff <= uuid_hi_in;
         uuid_lo_ff <= uuid_lo_in;
      end
   end

endmodule

// ----- rtl/adrp_fifo.sv -----
module adrp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  adrp_pkg::adrp_pair_type push,
   output logic                   room,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output adrp_pkg::adrp_rsp_type  rsp_data
);

   localparam int AW = $clog2(adrp_pkg::FIFO_DEPTH);
   localparam int CW = $clog2(adrp_pkg::FIFO_DEPTH + 1);

   adrp_pkg::adrp_rsp_type mem [adrp_pkg::FIFO_DEPTH];

   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic [AW-1:0] wr_ff, wr_in;
   logic          pop;
   logic [1:0]    npush;
   adrp_pkg::adrp_rsp_type first;

   assign pop      = (count_ff != '0) && !rsp_stall;
   assign npush    = {1'b0, push.rec_valid} + {1'b0, push.sum_valid};
   assign first    = push.rec_valid ? push.rec : push.sum;
   assign count_in = CW'(count_ff + CW'(npush) - CW'(pop));
   assign rd_in    = AW'(rd_ff + AW'(pop));
   assign wr_in    = AW'(wr_ff + AW'(npush));
   // one byte may bring two results
   assign room      = CW'(count_ff - CW'(pop)) <= CW'(adrp_pkg::FIFO_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = mem[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= '0;
         wr_ff    <= '0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (npush != 2'd0) begin
         mem[wr_ff] <= first;
      end
      if (npush == 2'd2) begin
         mem[AW'(wr_ff + 1'b1)] <= push.sum;
      end
   end

endmodule

// ----- rtl/att_discovery_response_parser.sv -----
// ATT discovery response parser.
// req_*: one PDU byte per item, opcode first, each carrying the total PDU
// length. Read By Group Type and Find Information responses are parsed.
// rsp_*: one record per complete entry (handles plus 128-bit UUID), and a
// summary item after the last byte of every PDU. A byte yields zero, one or
// two result items; run_last marks the last one for that byte.
// A byte accepted into the input register is parsed once the result queue
// has room, and its results enter the queue together; a second result
// follows the first on rsp_*. Throughput is one byte per cycle while the
// result queue has room: the input register holds a byte while it is
// parsed, and a four-entry queue absorbs a PDU's extra summary item.
// req_stall rises when a byte is held and the result queue lacks space for
// two results; a stalled receiver backs up into the input within a few items.
// Synchronous reset empties the input register and result queue and returns
// the parser to expect an opcode byte.
module att_discovery_response_parser #(
   parameter int MAX_PDU_BYTES = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  adrp_pkg::adrp_req_type  req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output adrp_pkg::adrp_rsp_type  rsp_data
);

   logic                    in_valid_ff, in_valid_in;
   adrp_pkg::adrp_req_type  in_data_ff;
   logic                    room;
   logic                    fire;
   logic                    accept;
   adrp_pkg::adrp_pair_type pair;

   assign fire        = in_valid_ff && room;
   assign req_stall   = in_valid_ff && !room;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
   end

   adrp_parser #(
      .MAX_PDU_BYTES(MAX_PDU_BYTES)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (in_data_ff),
      .results (pair)
   );

   adrp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (pair),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/adrp_checker.sv -----
module adrp_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input adrp_pkg::adrp_rsp_type  rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == adrp_pkg::KIND_SUMMARY |->
         rsp_data.run_last && rsp_data.first_handle == 16'h0000 &&
         rsp_data.uuid_upper == 64'h0 && rsp_data.uuid_lower == 64'h0 &&
         (rsp_data.final_handle_valid || rsp_data.final_handle == 16'h0000))
      else $error("malformed summary item");

   a_record_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != adrp_pkg::KIND_SUMMARY |->
         rsp_data.parse_status == adrp_pkg::ST_OK && !rsp_data.final_handle_valid &&
         rsp_data.final_handle == 16'h0000 &&
         (rsp_data.kind == adrp_pkg::KIND_GROUP || rsp_data.group_end_handle == 16'h0000))
      else $error("record carries summary fields");

endmodule

bind att_discovery_response_parser adrp_checker u_adrp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
